[hw/rtl/b32enc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32enc_pkg: shared types and constants
// Modes, status codes, datapath command/status structs, checksum step, charset.
// ----------------------------------------------------------------------------
package b32enc_pkg;

	localparam logic [1:0] MODE_PREFIX = 2'd0;
	localparam logic [1:0] MODE_DATA   = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_LONG    = 2'd1;
	localparam logic [1:0] ST_CAP     = 2'd2;
	localparam logic [1:0] ST_ENCFAIL = 2'd3;

	localparam logic [1:0] REG_VARIANT  = 2'd0;
	localparam logic [1:0] REG_PAD      = 2'd1;
	localparam logic [1:0] REG_CAPACITY = 2'd2;

	localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;
	localparam logic [7:0]  SEP_CHAR      = 8'h31;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENTER_ZERO,
		S_REPLAY,
		S_SEP,
		S_GROUPS,
		S_PAD,
		S_ZEROS,
		S_CHECK,
		S_CLEAR
	} state_t;

	// Output character source.
	typedef enum logic [2:0] {
		SRC_ECHO,
		SRC_SEP,
		SRC_GROUP,
		SRC_PAD,
		SRC_CHECK
	} src_t;

	typedef struct packed {
		logic        latch_in;      // capture input item
		logic        prefix_ok;     // store prefix char, step checksum
		logic        set_char_err;
		logic        set_prefix_err;
		logic        set_bytes_err;
		logic        zero_step;     // checksum step with zero input
		logic        replay_step;   // checksum step with stored prefix entry
		logic        replay_next;
		logic        set_data;
		logic        load_byte;     // shift byte into accumulator
		logic        group_step;    // consume one 5-bit group
		logic        pad_step;
		logic        apply_const;
		logic        clear_msg;
		logic        emit;
		src_t        src;
		logic [2:0]  idx;           // zero step / checksum char counter
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       in_data;
		logic       char_bad;
		logic       prefix_full;
		logic       bytes_full;
		logic       replay_done;
		logic       group_avail;
		logic       pad_needed;
	} sts_t;

	function automatic logic [29:0] poly_step(input logic [29:0] c);
		logic [29:0] r;
		r = {c[24:0], 5'd0};
		if (c[25]) r = r ^ 30'h3b6a57b2;
		if (c[26]) r = r ^ 30'h26508e6d;
		if (c[27]) r = r ^ 30'h1ea119fa;
		if (c[28]) r = r ^ 30'h3d4233dd;
		if (c[29]) r = r ^ 30'h2a1462b3;
		return r;
	endfunction

	function automatic logic [7:0] charset(input logic [4:0] g);
		logic [7:0] c;
		unique case (g)
			5'd0:  c = "q"; 5'd1:  c = "p"; 5'd2:  c = "z"; 5'd3:  c = "r";
			5'd4:  c = "y"; 5'd5:  c = "9"; 5'd6:  c = "x"; 5'd7:  c = "8";
			5'd8:  c = "g"; 5'd9:  c = "f"; 5'd10: c = "2"; 5'd11: c = "t";
			5'd12: c = "v"; 5'd13: c = "d"; 5'd14: c = "w"; 5'd15: c = "0";
			5'd16: c = "s"; 5'd17: c = "3"; 5'd18: c = "j"; 5'd19: c = "n";
			5'd20: c = "5"; 5'd21: c = "4"; 5'd22: c = "k"; 5'd23: c = "h";
			5'd24: c = "c"; 5'd25: c = "e"; 5'd26: c = "6"; 5'd27: c = "m";
			5'd28: c = "u"; 5'd29: c = "a"; 5'd30: c = "7"; 5'd31: c = "l";
			default: c = "q";
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/bech32_string_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bech32_string_encoder: streaming Bech32 / Bech32m string encoder
// Echoes prefix characters, emits separator, data groups and checksum.
// ----------------------------------------------------------------------------
// Feed a message as prefix characters (mode 0), data bytes (mode 1) and one
// finish item (mode 2), with the mode in tuser and the character or byte in
// tdata. One item is in work at a time. A prefix character is accepted and
// decoded. A data byte after the first is accepted, decoded and loaded,
// then emits its one or two 5-bit groups, and a last step finds no group
// left. The first data byte, or the finish of a message without data, first
// replays each stored prefix character with a read step and a checksum step,
// set by the single registered read port of the prefix store, then finds the
// replay done and emits the separator. Finish after data is accepted and
// decoded, then runs the optional pad group, six checksum steps and one for
// the final constant, six characters and a clear step. Output stalls hold
// the sequencer. The last character of a message carries tlast and the
// status in tuser; discard the message when status is not zero.
// ----------------------------------------------------------------------------
module bech32_string_encoder #(
	parameter int MAX_BYTES    = 280,
	parameter int PREFIX_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] value
	input  logic [1:0]  s_axis_tuser,   // [1:0] mode
	// Output characters
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] char_code
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser    // [1:0] status
);
	import b32enc_pkg::*;

	logic        variant_q;
	logic        pad_final_q;
	logic [15:0] out_capacity_q;
	cmd_t        cmd;
	sts_t        sts;

	// Hold configuration registers; the user must write them only while idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q      <= 1'b0;
			pad_final_q    <= 1'b1;
			out_capacity_q <= 16'd280;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VARIANT:  variant_q      <= cfg_data[0];
				REG_PAD:      pad_final_q    <= cfg_data[0];
				REG_CAPACITY: out_capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	b32enc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	b32enc_datapath #(
		.MAX_BYTES   (MAX_BYTES),
		.PREFIX_DEPTH(PREFIX_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_mode     (s_axis_tuser),
		.in_value    (s_axis_tdata),
		.variant     (variant_q),
		.pad_final   (pad_final_q),
		.out_capacity(out_capacity_q),
		.out_char    (m_axis_tdata),
		.out_last    (m_axis_tlast),
		.out_status  (m_axis_tuser)
	);
endmodule

[hw/rtl/b32enc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32enc_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module b32enc_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

[hw/rtl/b32enc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32enc_datapath: checksum, prefix store, bit regrouping, length checks
// Executes controller commands and drives the output character register.
// ----------------------------------------------------------------------------
module b32enc_datapath #(
	parameter int MAX_BYTES    = 280,
	parameter int PREFIX_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  b32enc_pkg::cmd_t   cmd,
	output b32enc_pkg::sts_t   sts,
	input  logic [1:0]         in_mode,
	input  logic [7:0]         in_value,
	input  logic               variant,
	input  logic               pad_final,
	input  logic [15:0]        out_capacity,
	output logic [7:0]         out_char,
	output logic               out_last,
	output logic [1:0]         out_status
);
	import b32enc_pkg::*;

	localparam int AW = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
	localparam int CW = $clog2(PREFIX_DEPTH + 1);
	localparam int BW = $clog2(MAX_BYTES + 1);

	logic [1:0]    mode_q;
	logic [7:0]    value_q;
	logic [29:0]   chk_q;
	logic [CW-1:0] pcount_q;
	logic [CW-1:0] rptr_q;
	logic [11:0]   acc_q;
	logic [3:0]    pend_q;
	logic          in_data_q;
	logic [BW-1:0] bytes_q;
	logic [9:0]    groups_q;
	logic [2:0]    err_q;
	logic [4:0]    rdata;
	logic [4:0]    grp;
	logic [4:0]    padg;
	logic [3:0]    pend_m5;
	logic [1:0]    st;
	logic [4:0]    cgrp;
	logic [11:0]   total;

	b32enc_ram #(.WIDTH(5), .DEPTH(PREFIX_DEPTH)) u_store (
		.clk  (clk),
		.we   (cmd.prefix_ok),
		.waddr(pcount_q[AW-1:0]),
		.wdata(value_q[4:0]),
		.raddr(rptr_q[AW-1:0]),
		.rdata(rdata)
	);

	assign pend_m5 = pend_q - 4'd5;
	assign grp     = 5'((acc_q >> pend_m5) & 12'h1F);
	assign padg    = 5'((acc_q << (4'd5 - pend_q)) & 12'h1F);
	assign total   = 12'(pcount_q) + 12'd7 + 12'(groups_q);
	assign cgrp    = 5'(chk_q >> (5'(3'd5 - cmd.idx) * 5'd5));

	always_comb begin
		if (err_q[0]) st = ST_LONG;
		else if (out_capacity < 16'(MAX_BYTES)) st = ST_CAP;
		else if (16'(groups_q) >= out_capacity) st = ST_LONG;
		else if (err_q[1] || err_q[2] || total > 12'(2 * MAX_BYTES)) st = ST_ENCFAIL;
		else st = ST_OK;
	end

	assign sts.mode        = mode_q;
	assign sts.in_data     = in_data_q;
	assign sts.char_bad    = (value_q < 8'd33) || (value_q > 8'd126) ||
		((value_q >= 8'd65) && (value_q <= 8'd90));
	assign sts.prefix_full = (pcount_q >= CW'(PREFIX_DEPTH));
	assign sts.bytes_full  = (bytes_q >= BW'(MAX_BYTES));
	assign sts.replay_done = (rptr_q >= pcount_q);
	assign sts.group_avail = (pend_q >= 4'd5);
	assign sts.pad_needed  = pad_final && (pend_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q     <= 30'd1;
			pcount_q  <= '0;
			rptr_q    <= '0;
			acc_q     <= '0;
			pend_q    <= '0;
			in_data_q <= 1'b0;
			bytes_q   <= '0;
			groups_q  <= '0;
			err_q     <= '0;
		end else if (cmd.clear_msg) begin
			chk_q     <= 30'd1;
			pcount_q  <= '0;
			rptr_q    <= '0;
			acc_q     <= '0;
			pend_q    <= '0;
			in_data_q <= 1'b0;
			bytes_q   <= '0;
			groups_q  <= '0;
			err_q     <= '0;
		end else begin
			if (cmd.set_bytes_err)  err_q[0] <= 1'b1;
			if (cmd.set_char_err)   err_q[1] <= 1'b1;
			if (cmd.set_prefix_err) err_q[2] <= 1'b1;
			if (cmd.prefix_ok) begin
				chk_q    <= poly_step(chk_q) ^ 30'(value_q[7:5]);
				pcount_q <= pcount_q + 1'b1;
			end
			if (cmd.zero_step) chk_q <= poly_step(chk_q);
			if (cmd.replay_step) chk_q <= poly_step(chk_q) ^ 30'(rdata);
			if (cmd.replay_next) rptr_q <= rptr_q + 1'b1;
			if (cmd.set_data) in_data_q <= 1'b1;
			if (cmd.load_byte) begin
				acc_q   <= {acc_q[3:0], value_q};
				pend_q  <= pend_q + 4'd8;
				bytes_q <= bytes_q + 1'b1;
			end
			if (cmd.group_step) begin
				chk_q    <= poly_step(chk_q) ^ 30'(grp);
				pend_q   <= pend_m5;
				acc_q    <= acc_q & ((12'd1 << pend_m5) - 12'd1);
				groups_q <= groups_q + 10'd1;
			end
			if (cmd.pad_step) begin
				chk_q    <= poly_step(chk_q) ^ 30'(padg);
				pend_q   <= '0;
				acc_q    <= '0;
				groups_q <= groups_q + 10'd1;
			end
			if (cmd.apply_const) chk_q <= chk_q ^ (variant ? BECH32M_CONST : 30'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mode_q  <= in_mode;
			value_q <= in_value;
		end
		if (cmd.emit) begin
			unique case (cmd.src)
				SRC_ECHO:  out_char <= value_q;
				SRC_SEP:   out_char <= SEP_CHAR;
				SRC_GROUP: out_char <= charset(grp);
				SRC_PAD:   out_char <= charset(padg);
				SRC_CHECK: out_char <= charset(cgrp);
				default:   out_char <= value_q;
			endcase
			out_last   <= cmd.last;
			out_status <= cmd.last ? st : ST_OK;
		end
	end
endmodule

[hw/rtl/b32enc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32enc_ctrl: sequencing state machine
// Accepts items, steps the datapath and holds one output character.
// ----------------------------------------------------------------------------
module b32enc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output b32enc_pkg::cmd_t cmd,
	input  b32enc_pkg::sts_t sts
);
	import b32enc_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] idx_q, idx_d;
	logic       ov_q, ov_d;
	logic       free;

	// Output slot is free when empty or being drained this cycle.
	assign free      = !ov_q || out_ready;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			ov_q    <= ov_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		ov_d     = ov_q && !out_ready;
		cmd      = '0;
		cmd.src  = SRC_ECHO;
		cmd.idx  = idx_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
				if (in_valid) state_d = S_ENTER_ZERO;
			end
			S_ENTER_ZERO: begin
				// Decode the latched item.
				unique case (sts.mode)
					MODE_PREFIX: begin
						if (sts.in_data) begin
							cmd.set_prefix_err = 1'b1;
							state_d = S_IDLE;
						end else if (free) begin
							cmd.emit = 1'b1;
							ov_d     = 1'b1;
							if (sts.char_bad) cmd.set_char_err = 1'b1;
							else if (sts.prefix_full) cmd.set_prefix_err = 1'b1;
							else cmd.prefix_ok = 1'b1;
							state_d = S_IDLE;
						end
					end
					MODE_DATA: begin
						if (sts.bytes_full) begin
							cmd.set_bytes_err = 1'b1;
							state_d = S_IDLE;
						end else if (sts.in_data) begin
							cmd.load_byte = 1'b1;
							state_d = S_GROUPS;
						end else begin
							cmd.zero_step = 1'b1;
							state_d = S_REPLAY;
						end
					end
					MODE_FINISH: begin
						if (sts.in_data) state_d = S_PAD;
						else begin
							cmd.zero_step = 1'b1;
							state_d = S_REPLAY;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_REPLAY: begin
				// RAM read data is registered: pointer advances, step next cycle.
				if (idx_q == 3'd0) begin
					if (sts.replay_done) state_d = S_SEP;
					else begin
						cmd.replay_next = 1'b1;
						idx_d = 3'd1;
					end
				end else begin
					cmd.replay_step = 1'b1;
					idx_d = 3'd0;
				end
			end
			S_SEP: begin
				if (free) begin
					cmd.emit     = 1'b1;
					cmd.src      = SRC_SEP;
					cmd.set_data = 1'b1;
					ov_d         = 1'b1;
					if (sts.mode == MODE_DATA) begin
						cmd.load_byte = 1'b1;
						state_d = S_GROUPS;
					end else state_d = S_PAD;
				end
			end
			S_GROUPS: begin
				if (!sts.group_avail) state_d = S_IDLE;
				else if (free) begin
					cmd.emit       = 1'b1;
					cmd.src        = SRC_GROUP;
					cmd.group_step = 1'b1;
					ov_d           = 1'b1;
				end
			end
			S_PAD: begin
				if (!sts.pad_needed) begin
					idx_d   = 3'd0;
					state_d = S_ZEROS;
				end else if (free) begin
					cmd.emit     = 1'b1;
					cmd.src      = SRC_PAD;
					cmd.pad_step = 1'b1;
					ov_d         = 1'b1;
					idx_d        = 3'd0;
					state_d      = S_ZEROS;
				end
			end
			S_ZEROS: begin
				if (idx_q == 3'd6) begin
					cmd.apply_const = 1'b1;
					idx_d   = 3'd0;
					state_d = S_CHECK;
				end else begin
					cmd.zero_step = 1'b1;
					idx_d = idx_q + 3'd1;
				end
			end
			S_CHECK: begin
				if (free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_CHECK;
					cmd.last = (idx_q == 3'd5);
					ov_d     = 1'b1;
					if (idx_q == 3'd5) begin
						idx_d   = 3'd0;
						state_d = S_CLEAR;
					end else idx_d = idx_q + 3'd1;
				end
			end
			S_CLEAR: begin
				cmd.clear_msg = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
